/* rtl/core/tss_pkg.sv */
// shared types and constants for the two-literal clause satisfiability block
// no dependencies

package tss_pkg;

   localparam int VAR_W      = 9;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [0:0] {
      OP_ADD   = 1'b0,
      OP_SOLVE = 1'b1
   } opcode_type;

   typedef struct packed {
      logic             neg_b;
      logic [VAR_W-1:0] var_b;
      logic             neg_a;
      logic [VAR_W-1:0] var_a;
   } clause_type;

   localparam int CLAUSE_W = $bits(clause_type);

   typedef struct packed {
      logic             start;
      logic             slot_free;
      logic [VAR_W-1:0] num_vars;
   } ctrl_type;

   typedef struct packed {
      logic busy;
      logic res_valid;
      logic sat;
      logic bad;
   } status_type;

endpackage

/* rtl/core/tss_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies

module tss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* rtl/core/tss_solver.sv */
// solve sequencer: builds the edge list, runs two depth-first passes and checks components
// depends on tss_pkg and tss_ram

module tss_solver #(
   parameter int MAX_VARS    = 256,
   parameter int MAX_CLAUSES = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tss_pkg::ctrl_type            ctrl,
   input  logic [$clog2(MAX_CLAUSES+1)-1:0] clause_count,
   output logic [((MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1)-1:0] cl_raddr,
   input  tss_pkg::clause_type          cl_rdata,
   output tss_pkg::status_type          status
);
   import tss_pkg::*;

   localparam int NODES = 2 * MAX_VARS + 1;
   localparam int NW    = $clog2(2 * MAX_VARS + 2);
   localparam int NAW   = $clog2(NODES);
   localparam int FAW   = $clog2(2 * MAX_VARS);
   localparam int EDGES = 2 * MAX_CLAUSES;
   localparam int EW    = $clog2(EDGES + 1);
   localparam int EAW   = $clog2(EDGES);
   localparam int CW    = $clog2(MAX_CLAUSES + 1);
   localparam int CAW   = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
   localparam int CPW   = (NW > VAR_W) ? NW : VAR_W;
   localparam int SW    = NW + EW;

   typedef enum logic [17:0] {
      ST_IDLE   = 18'h00001,
      ST_CL_RD  = 18'h00002,
      ST_CL_EV  = 18'h00004,
      ST_CL_E2  = 18'h00008,
      ST_VCLR   = 18'h00010,
      ST_P1_RD  = 18'h00020,
      ST_P1_TST = 18'h00040,
      ST_P2_RD  = 18'h00080,
      ST_P2_VRD = 18'h00100,
      ST_P2_TST = 18'h00200,
      ST_STEP   = 18'h00400,
      ST_EDGE   = 18'h00800,
      ST_VIS    = 18'h01000,
      ST_POP    = 18'h02000,
      ST_CK_A   = 18'h04000,
      ST_CK_B   = 18'h08000,
      ST_CK_C   = 18'h10000,
      ST_DONE   = 18'h20000
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    k_cl_ff, k_cl_in;
   logic [EW-1:0]    ne_ff, ne_in;
   logic [2*NW-1:0]  e2_ff, e2_in;
   logic             pass_ff, pass_in;
   logic [NW-1:0]    i_ff, i_in;
   logic [NW-1:0]    k_ff, k_in;
   logic [NW-1:0]    flen_ff, flen_in;
   logic [NW-1:0]    comp_ff, comp_in;
   logic [NW-1:0]    sp_ff, sp_in;
   logic [NW-1:0]    top_node_ff, top_node_in;
   logic [EW-1:0]    top_cur_ff, top_cur_in;
   logic [NW-1:0]    w_ff, w_in;
   logic [NW-1:0]    ca_ff, ca_in;
   logic             sat_ff, sat_in;
   logic             bad_ff, bad_in;

   logic             vis_we, vis_wd, vis_rd;
   logic [NAW-1:0]   vis_wa, vis_ra;
   logic             edge_we;
   logic [EAW-1:0]   edge_wa, edge_ra;
   logic [2*NW-1:0]  edge_wd, edge_rd;
   logic             fin_we;
   logic [FAW-1:0]   fin_wa, fin_ra;
   logic [NW-1:0]    fin_rd;
   logic             comp_we;
   logic [NAW-1:0]   comp_wa, comp_ra;
   logic [NW-1:0]    comp_rd;
   logic             stk_we;
   logic [FAW-1:0]   stk_wa, stk_ra;
   logic [SW-1:0]    stk_wd, stk_rd;

   logic [NW-1:0]    n_node, nodes, pa, ma, pb, mb, e_src, e_dst;
   logic             a_bad, b_bad;

   tss_ram #(.WIDTH(1), .DEPTH(NODES)) u_visited (
      .clock(clock), .wr_en(vis_we), .wr_addr(vis_wa), .wr_data(vis_wd),
      .rd_addr(vis_ra), .rd_data(vis_rd));

   tss_ram #(.WIDTH(2*NW), .DEPTH(EDGES)) u_edges (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_wa), .wr_data(edge_wd),
      .rd_addr(edge_ra), .rd_data(edge_rd));

   tss_ram #(.WIDTH(NW), .DEPTH(2*MAX_VARS)) u_finish (
      .clock(clock), .wr_en(fin_we), .wr_addr(fin_wa), .wr_data(top_node_ff),
      .rd_addr(fin_ra), .rd_data(fin_rd));

   tss_ram #(.WIDTH(NW), .DEPTH(NODES)) u_comp (
      .clock(clock), .wr_en(comp_we), .wr_addr(comp_wa), .wr_data(comp_ff),
      .rd_addr(comp_ra), .rd_data(comp_rd));

   tss_ram #(.WIDTH(SW), .DEPTH(2*MAX_VARS)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_addr(stk_ra), .rd_data(stk_rd));

   always_comb begin
      n_node = NW'(ctrl.num_vars);
      nodes  = NW'(n_node << 1);
      a_bad  = CPW'(cl_rdata.var_a) > CPW'(ctrl.num_vars);
      b_bad  = CPW'(cl_rdata.var_b) > CPW'(ctrl.num_vars);
      pa = cl_rdata.neg_a ? NW'(cl_rdata.var_a) + n_node : NW'(cl_rdata.var_a);
      ma = cl_rdata.neg_a ? NW'(cl_rdata.var_a) : NW'(cl_rdata.var_a) + n_node;
      pb = cl_rdata.neg_b ? NW'(cl_rdata.var_b) + n_node : NW'(cl_rdata.var_b);
      mb = cl_rdata.neg_b ? NW'(cl_rdata.var_b) : NW'(cl_rdata.var_b) + n_node;
      e_src = pass_ff ? edge_rd[NW-1:0] : edge_rd[2*NW-1:NW];
      e_dst = pass_ff ? edge_rd[2*NW-1:NW] : edge_rd[NW-1:0];
   end

   always_comb begin
      state_in    = state_ff;
      k_cl_in     = k_cl_ff;
      ne_in       = ne_ff;
      e2_in       = e2_ff;
      pass_in     = pass_ff;
      i_in        = i_ff;
      k_in        = k_ff;
      flen_in     = flen_ff;
      comp_in     = comp_ff;
      sp_in       = sp_ff;
      top_node_in = top_node_ff;
      top_cur_in  = top_cur_ff;
      w_in        = w_ff;
      ca_in       = ca_ff;
      sat_in      = sat_ff;
      bad_in      = bad_ff;

      cl_raddr = CAW'(k_cl_ff);
      vis_we   = 1'b0;
      vis_wa   = NAW'(top_node_ff);
      vis_wd   = 1'b1;
      vis_ra   = NAW'(i_ff);
      edge_we  = 1'b0;
      edge_wa  = EAW'(ne_ff);
      edge_wd  = e2_ff;
      edge_ra  = EAW'(top_cur_ff);
      fin_we   = 1'b0;
      fin_wa   = FAW'(flen_ff);
      fin_ra   = FAW'(k_ff - 1'b1);
      comp_we  = 1'b0;
      comp_wa  = NAW'(top_node_ff);
      comp_ra  = NAW'(i_ff);
      stk_we   = 1'b0;
      stk_wa   = FAW'(sp_ff - 1'b1);
      stk_wd   = {top_node_ff, top_cur_ff};
      stk_ra   = FAW'(sp_ff - NW'(2));

      unique case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               k_cl_in  = '0;
               ne_in    = '0;
               bad_in   = 1'b0;
               state_in = ST_CL_RD;
            end
         end
         ST_CL_RD: begin
            if (k_cl_ff == clause_count) begin
               pass_in  = 1'b0;
               i_in     = '0;
               state_in = ST_VCLR;
            end else begin
               state_in = ST_CL_EV;
            end
         end
         ST_CL_EV: begin
            k_cl_in  = k_cl_ff + 1'b1;
            state_in = ST_CL_RD;
            if (a_bad || b_bad) begin
               bad_in = 1'b1;
            end else if (cl_rdata.var_a == '0 && cl_rdata.var_b == '0) begin
               bad_in = bad_ff;
            end else begin
               edge_we = 1'b1;
               ne_in   = ne_ff + 1'b1;
               if (cl_rdata.var_a == '0) begin
                  edge_wd = {mb, pb};
               end else if (cl_rdata.var_b == '0) begin
                  edge_wd = {ma, pa};
               end else begin
                  edge_wd  = {ma, pb};
                  e2_in    = {mb, pa};
                  state_in = ST_CL_E2;
               end
            end
         end
         ST_CL_E2: begin
            edge_we  = 1'b1;
            ne_in    = ne_ff + 1'b1;
            state_in = ST_CL_RD;
         end
         ST_VCLR: begin
            vis_we = 1'b1;
            vis_wa = NAW'(i_ff);
            vis_wd = 1'b0;
            i_in   = i_ff + 1'b1;
            if (i_ff == NW'(NODES - 1)) begin
               if (pass_ff) begin
                  k_in     = flen_ff;
                  comp_in  = '0;
                  state_in = ST_P2_RD;
               end else begin
                  i_in     = NW'(1);
                  flen_in  = '0;
                  state_in = ST_P1_RD;
               end
            end
         end
         ST_P1_RD: begin
            if (i_ff > nodes) begin
               pass_in  = 1'b1;
               i_in     = '0;
               state_in = ST_VCLR;
            end else begin
               state_in = ST_P1_TST;
            end
         end
         ST_P1_TST: begin
            if (vis_rd) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_P1_RD;
            end else begin
               vis_we      = 1'b1;
               vis_wa      = NAW'(i_ff);
               top_node_in = i_ff;
               top_cur_in  = '0;
               sp_in       = NW'(1);
               state_in    = ST_STEP;
            end
         end
         ST_P2_RD: begin
            if (k_ff == '0) begin
               i_in     = NW'(1);
               state_in = ST_CK_A;
            end else begin
               state_in = ST_P2_VRD;
            end
         end
         ST_P2_VRD: begin
            w_in     = fin_rd;
            vis_ra   = NAW'(fin_rd);
            state_in = ST_P2_TST;
         end
         ST_P2_TST: begin
            if (vis_rd) begin
               k_in     = k_ff - 1'b1;
               state_in = ST_P2_RD;
            end else begin
               vis_we      = 1'b1;
               vis_wa      = NAW'(w_ff);
               comp_in     = comp_ff + 1'b1;
               top_node_in = w_ff;
               top_cur_in  = '0;
               sp_in       = NW'(1);
               state_in    = ST_STEP;
            end
         end
         ST_STEP: begin
            if (top_cur_ff == ne_ff) begin
               if (pass_ff) begin
                  comp_we = 1'b1;
               end else begin
                  fin_we  = 1'b1;
                  flen_in = flen_ff + 1'b1;
               end
               sp_in = sp_ff - 1'b1;
               if (sp_ff == NW'(1)) begin
                  if (pass_ff) begin
                     k_in     = k_ff - 1'b1;
                     state_in = ST_P2_RD;
                  end else begin
                     i_in     = i_ff + 1'b1;
                     state_in = ST_P1_RD;
                  end
               end else begin
                  state_in = ST_POP;
               end
            end else begin
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            top_cur_in = top_cur_ff + 1'b1;
            if (e_src == top_node_ff) begin
               w_in     = e_dst;
               vis_ra   = NAW'(e_dst);
               state_in = ST_VIS;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_VIS: begin
            if (!vis_rd) begin
               vis_we      = 1'b1;
               vis_wa      = NAW'(w_ff);
               stk_we      = 1'b1;
               top_node_in = w_ff;
               top_cur_in  = '0;
               sp_in       = sp_ff + 1'b1;
            end
            state_in = ST_STEP;
         end
         ST_POP: begin
            top_node_in = stk_rd[SW-1:EW];
            top_cur_in  = stk_rd[EW-1:0];
            state_in    = ST_STEP;
         end
         ST_CK_A: begin
            if (CPW'(i_ff) > CPW'(ctrl.num_vars)) begin
               sat_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_CK_B;
            end
         end
         ST_CK_B: begin
            ca_in    = comp_rd;
            comp_ra  = NAW'(i_ff + n_node);
            state_in = ST_CK_C;
         end
         ST_CK_C: begin
            if (ca_ff == comp_rd) begin
               sat_in   = 1'b0;
               state_in = ST_DONE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_CK_A;
            end
         end
         ST_DONE: begin
            if (ctrl.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      k_cl_ff     <= k_cl_in;
      ne_ff       <= ne_in;
      e2_ff       <= e2_in;
      pass_ff     <= pass_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      flen_ff     <= flen_in;
      comp_ff     <= comp_in;
      sp_ff       <= sp_in;
      top_node_ff <= top_node_in;
      top_cur_ff  <= top_cur_in;
      w_ff        <= w_in;
      ca_ff       <= ca_in;
      sat_ff      <= sat_in;
      bad_ff      <= bad_in;
   end

   assign status.busy      = (state_ff != ST_IDLE);
   assign status.res_valid = (state_ff == ST_DONE);
   assign status.sat       = sat_ff;
   assign status.bad       = bad_ff;

endmodule

/* rtl/core/two_sat_solver.sv */
// top level of the two-literal clause satisfiability block: clause store, load path, result register
// depends on tss_pkg, tss_ram and tss_solver
//
// usage:
//   req channel carries one item per handshake: an add item stores one clause, a solve item
//   decides whether all stored clauses hold together and produces one rsp item.
//   add items are taken one per cycle while no solve is running, with no result. clauses naming
//   a variable above csr_wr_data's num_vars, capped at MAX_VARS, are dropped and flag bad_variable;
//   clauses past MAX_CLAUSES are dropped and flag clauses_dropped. empty clauses are ignored.
//   a solve item keeps req_tready low until its result is loaded into the output register;
//   the edge scan in the walk sequencer dominates that time (each node scans the whole edge
//   list once in each of the two passes).
//   the result is held in an output register; while rsp_tready is low, add items are still
//   taken until the next solve item, and a finished solve waits for the register to free.
//   after a solve the clause store and both flags are cleared.
//   reset clears the clause count, flags and the sequencer; num_vars returns to 256.
//   csr writes are registered; the user must make them only while the block is idle (not enforced).

module two_sat_solver #(
   parameter int MAX_VARS    = 256,
   parameter int MAX_CLAUSES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // opcode[0], var_a[9:1], neg_a[10], var_b[19:11], neg_b[20], zero fill
   input  logic [tss_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // satisfiable[0], clauses_dropped[1], bad_variable[2], zero fill
   output logic [tss_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [tss_pkg::VAR_W-1:0]         csr_wr_data
);
   import tss_pkg::*;

   localparam int CW  = $clog2(MAX_CLAUSES + 1);
   localparam int CAW = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
   localparam int CPW = (VAR_W > 16) ? VAR_W : 16;

   logic [VAR_W-1:0] num_vars_ff, num_vars_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             rng_ff, rng_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_bits_ff, rsp_bits_in;

   opcode_type       op;
   clause_type       cl_in;
   logic [VAR_W-1:0] n_eff;
   logic             accept, slot_free, st_we;
   logic [CAW-1:0]   cl_raddr;
   clause_type       cl_rdata;
   ctrl_type         ctrl;
   status_type       status;

   assign op          = opcode_type'(req_tdata[0]);
   assign cl_in.var_a = req_tdata[9:1];
   assign cl_in.neg_a = req_tdata[10];
   assign cl_in.var_b = req_tdata[19:11];
   assign cl_in.neg_b = req_tdata[20];

   assign n_eff      = (CPW'(num_vars_ff) > CPW'(MAX_VARS)) ? VAR_W'(MAX_VARS) : num_vars_ff;
   assign req_tready = !status.busy;
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign ctrl.start     = accept && (op == OP_SOLVE);
   assign ctrl.slot_free = slot_free;
   assign ctrl.num_vars  = n_eff;

   tss_ram #(.WIDTH(CLAUSE_W), .DEPTH(MAX_CLAUSES)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(CAW'(count_ff)), .wr_data(cl_in),
      .rd_addr(cl_raddr), .rd_data(cl_rdata));

   tss_solver #(.MAX_VARS(MAX_VARS), .MAX_CLAUSES(MAX_CLAUSES)) u_solver (
      .clock(clock), .reset(reset), .ctrl(ctrl), .clause_count(count_ff),
      .cl_raddr(cl_raddr), .cl_rdata(cl_rdata), .status(status));

   always_comb begin
      num_vars_in  = csr_wr_en ? csr_wr_data : num_vars_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rng_in       = rng_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_bits_in  = rsp_bits_ff;
      st_we        = 1'b0;
      if (accept && op == OP_ADD) begin
         if (cl_in.var_a > n_eff || cl_in.var_b > n_eff) begin
            rng_in = 1'b1;
         end else if (cl_in.var_a == '0 && cl_in.var_b == '0) begin
            rng_in = rng_ff;
         end else if (count_ff == CW'(MAX_CLAUSES)) begin
            ovf_in = 1'b1;
         end else begin
            st_we    = 1'b1;
            count_in = count_ff + 1'b1;
         end
      end
      if (status.res_valid && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_bits_in  = {status.bad || rng_ff, ovf_ff, status.sat};
         count_in     = '0;
         ovf_in       = 1'b0;
         rng_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vars_ff  <= VAR_W'(256);
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rng_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         num_vars_ff  <= num_vars_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rng_ff       <= rng_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_bits_ff <= rsp_bits_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-3)'(0), rsp_bits_ff};

endmodule

/* verif/tss_checker.sv */
// checker for two_sat_solver: watches req, rsp and csr, predicts each solve answer
// by strong-component search over the implication graph and compares rsp items
`timescale 1ns / 100ps

module tss_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data,
   output int          errors,
   output int          pending
);
   import tss_pkg::*;

   typedef struct packed {
      logic bad;
      logic dropped;
      logic sat;
   } answer_type;

   answer_type answers_q[$];

   clause_type clauses[1024];
   int         clause_cnt;
   bit         overflow_seen;
   bit         range_seen;
   logic [8:0] num_vars;

   int edge_src[2048], edge_dst[2048];
   int fwd_off[514], fwd_adj[2048], rev_off[514], rev_adj[2048], fill[514];
   bit seen[513];
   int order_list[513], order_len, comp_id[513];
   int stk_node[513], stk_cur[513];

   assign pending = answers_q.size();

   task automatic report(string what, int got, int want);
      $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
      errors++;
   endtask

   task automatic build_lists(int ne);
      for (int i = 0; i < 514; i++) begin
         fwd_off[i] = 0;
         rev_off[i] = 0;
      end
      for (int e = 0; e < ne; e++) begin
         fwd_off[edge_src[e] + 1]++;
         rev_off[edge_dst[e] + 1]++;
      end
      for (int i = 1; i < 514; i++) begin
         fwd_off[i] += fwd_off[i-1];
         rev_off[i] += rev_off[i-1];
      end
      for (int i = 0; i < 514; i++) fill[i] = fwd_off[i];
      for (int e = 0; e < ne; e++) fwd_adj[fill[edge_src[e]]++] = edge_dst[e];
      for (int i = 0; i < 514; i++) fill[i] = rev_off[i];
      for (int e = 0; e < ne; e++) rev_adj[fill[edge_dst[e]]++] = edge_src[e];
   endtask

   task automatic walk(int start, bit rev, int cid);
      int sp, u, p, w, lim;
      seen[start] = 1;
      stk_node[0] = start;
      stk_cur[0] = rev ? rev_off[start] : fwd_off[start];
      sp = 1;
      while (sp > 0) begin
         u = stk_node[sp-1];
         p = stk_cur[sp-1];
         lim = rev ? rev_off[u+1] : fwd_off[u+1];
         if (p < lim) begin
            w = rev ? rev_adj[p] : fwd_adj[p];
            stk_cur[sp-1] = p + 1;
            if (!seen[w]) begin
               seen[w] = 1;
               stk_node[sp] = w;
               stk_cur[sp] = rev ? rev_off[w] : fwd_off[w];
               sp++;
            end
         end else begin
            sp--;
            if (!rev) order_list[order_len++] = u;
            else comp_id[u] = cid;
         end
      end
   endtask

   task automatic solve_clauses(output bit sat, inout bit bad);
      int n, ne, a, b, pa, ma, pb, mb, cid;
      n = (num_vars > 256) ? 256 : num_vars;
      ne = 0;
      for (int k = 0; k < clause_cnt; k++) begin
         a = clauses[k].var_a;
         b = clauses[k].var_b;
         if (a > n || b > n) begin
            bad = 1;
         end else if (a != 0 || b != 0) begin
            pa = clauses[k].neg_a ? a + n : a;
            ma = clauses[k].neg_a ? a : a + n;
            pb = clauses[k].neg_b ? b + n : b;
            mb = clauses[k].neg_b ? b : b + n;
            if (a == 0) begin
               edge_src[ne] = mb; edge_dst[ne] = pb; ne++;
            end else if (b == 0) begin
               edge_src[ne] = ma; edge_dst[ne] = pa; ne++;
            end else begin
               edge_src[ne] = ma; edge_dst[ne] = pb; ne++;
               edge_src[ne] = mb; edge_dst[ne] = pa; ne++;
            end
         end
      end
      build_lists(ne);
      for (int i = 0; i < 513; i++) seen[i] = 0;
      order_len = 0;
      for (int i = 1; i <= 2 * n; i++) if (!seen[i]) walk(i, 0, 0);
      for (int i = 0; i < 513; i++) seen[i] = 0;
      cid = 0;
      for (int k = order_len; k > 0; k--) begin
         if (!seen[order_list[k-1]]) begin
            cid++;
            walk(order_list[k-1], 1, cid);
         end
      end
      sat = 1;
      for (int i = 1; i <= n; i++) if (comp_id[i] == comp_id[i+n]) sat = 0;
   endtask

   task automatic take_item(logic [23:0] d);
      answer_type ans;
      bit         sat, bad;
      int         n, a, b;
      if (opcode_type'(d[0]) == OP_ADD) begin
         n = (num_vars > 256) ? 256 : num_vars;
         a = d[9:1];
         b = d[19:11];
         if (a > n || b > n) range_seen = 1;
         else if (a == 0 && b == 0) ;
         else if (clause_cnt >= 1024) overflow_seen = 1;
         else clauses[clause_cnt++] = {d[20], d[19:11], d[10], d[9:1]};
      end else begin
         bad = range_seen;
         solve_clauses(sat, bad);
         ans.sat = sat;
         ans.dropped = overflow_seen;
         ans.bad = bad;
         answers_q = {answers_q, ans};
         clause_cnt = 0;
         overflow_seen = 0;
         range_seen = 0;
      end
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         answers_q.delete();
         clause_cnt = 0;
         overflow_seen = 0;
         range_seen = 0;
         num_vars = 9'd256;
      end else begin
         if (csr_wr_en) num_vars = csr_wr_data;
         if (req_tvalid && req_tready) take_item(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (answers_q.size() == 0) begin
               report("rsp item with none expected", rsp_tdata, 0);
            end else begin
               want = answers_q.pop_front();
               if (rsp_tdata[0] !== want.sat) report("satisfiable", rsp_tdata[0], want.sat);
               if (rsp_tdata[1] !== want.dropped)
                  report("clauses_dropped", rsp_tdata[1], want.dropped);
               if (rsp_tdata[2] !== want.bad) report("bad_variable", rsp_tdata[2], want.bad);
            end
         end
      end
   end

endmodule

/* verif/tb_top.sv */
// top of the two_sat_solver testbench: clock, reset, clause and solve stimulus, verdict
// depends on tss_pkg, two_sat_solver and tss_checker
`timescale 1ns / 100ps

module tb_top;
   import tss_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [7:0]  rsp_tdata;
   logic        csr_wr_en = 0;
   logic [8:0]  csr_wr_data = '0;
   int          errors, pending;
   bit          calm = 0;
   bit          hold_go = 0;
   int          item_cnt = 0, solve_cnt = 0;

   always #1 clock = ~clock;

   two_sat_solver DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   tss_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .errors(errors), .pending(pending)
   );

   task automatic send(opcode_type op, int a, bit na, int b, bit nb);
      req_tvalid <= 1;
      req_tdata <= {3'b000, nb, b[8:0], na, a[8:0], op};
      do @(posedge clock); while (!req_tready);
      item_cnt++;
      if (op == OP_SOLVE) solve_cnt++;
      if (!calm && $urandom_range(99) < 28) begin
         req_tvalid <= 0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic solve_junk();
      send(OP_SOLVE, $urandom_range(511), 1'($urandom_range(1)), $urandom_range(511),
           1'($urandom_range(1)));
   endtask

   task automatic set_vars(int v);
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v[8:0];
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   task automatic rand_clause(int n);
      int a, b;
      if ($urandom_range(99) < 6) begin
         a = $urandom_range(511);
         b = $urandom_range(511);
      end else begin
         a = $urandom_range(n);
         b = $urandom_range(n);
      end
      send(OP_ADD, a, 1'($urandom_range(1)), b, 1'($urandom_range(1)));
   endtask

   // receiver: random stalls, one long hold-off when asked
   initial begin
      bit held;
      held = 0;
      forever begin
         @(posedge clock);
         if (hold_go && !held) begin
            held = 1;
            rsp_tready <= 0;
            repeat (8000) @(posedge clock);
         end
         rsp_tready <= calm || ($urandom_range(99) >= 28);
      end
   end

   initial begin
      #20_000_000;
      $display("two_sat_solver: mismatch");
      $finish;
   end

   initial begin
      int n, nc;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // extremes at the reset width and at widths 1, 0 and 511, single literals, empty and out of range
      send(OP_ADD, 256, 1, 256, 0);
      send(OP_ADD, 1, 0, 0, 0);
      send(OP_ADD, 0, 0, 255, 1);
      send(OP_ADD, 0, 1, 0, 1);
      send(OP_ADD, 257, 0, 3, 0);
      send(OP_SOLVE, 511, 1, 511, 1);
      set_vars(1);
      send(OP_ADD, 1, 0, 0, 0);
      send(OP_ADD, 0, 0, 1, 1);
      send(OP_SOLVE, 0, 0, 0, 0);
      set_vars(0);
      send(OP_ADD, 1, 1, 0, 0);
      send(OP_ADD, 0, 0, 0, 0);
      send(OP_SOLVE, 0, 0, 0, 0);
      set_vars(511);
      send(OP_ADD, 256, 0, 1, 1);
      send(OP_ADD, 300, 0, 1, 1);
      send(OP_SOLVE, 0, 0, 0, 0);
      // width changed between loading and solving
      set_vars(8);
      send(OP_ADD, 7, 0, 2, 1);
      send(OP_ADD, 2, 0, 3, 0);
      set_vars(4);
      send(OP_SOLVE, 0, 0, 0, 0);

      // send more add items than the store can hold
      set_vars(3);
      repeat (1030) rand_clause(3);
      solve_junk();

      // long result hold-off while items keep coming
      set_vars(5);
      hold_go = 1;
      repeat (3) begin
         repeat (6) rand_clause(5);
         solve_junk();
      end

      while (item_cnt < 1250 || solve_cnt < 40) begin
         case ($urandom_range(9))
            0: n = 256;
            1: n = 0;
            2: n = $urandom_range(511, 257);
            default: n = $urandom_range(8, 1);
         endcase
         set_vars(n);
         calm = ($urandom_range(9) == 0);
         nc = (n > 16) ? $urandom_range(4) : $urandom_range(3 * n + 2);
         repeat (nc) rand_clause((n > 256) ? 256 : n);
         solve_junk();
         calm = 0;
      end

      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("two_sat_solver: match");
      end else begin
         $display("two_sat_solver: mismatch");
      end
      $finish;
   end

endmodule
